// ----- sv/rda_pkg.sv -----
// Package for the replica diffusion accumulator: field widths, codes,
// state type and saturating arithmetic helpers.
// No dependencies.
package rda_pkg;

    // Field widths of the channel words
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 5;
    localparam int SINCE_W = 32;
    localparam int DIFF_W  = 48;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [SINCE_W-1:0] MAX32     = 32'hFFFF_FFFF;
    localparam logic [DIFF_W-1:0]  MAX48     = 48'hFFFF_FFFF_FFFF;

    // Item codes
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_RD_ADDR,
        S_RD_DATA,
        S_OUT
    } t_state;

    // 32-bit increment that sticks at the top
    function automatic logic [SINCE_W-1:0] sat_inc32(input logic [SINCE_W-1:0] v);
        sat_inc32 = (v == MAX32) ? v : v + 32'd1;
    endfunction

    // 48-bit accumulate of a 32-bit value, saturating
    function automatic logic [DIFF_W-1:0] sat_add48(input logic [DIFF_W-1:0]  a,
                                                    input logic [SINCE_W-1:0] b);
        logic [DIFF_W:0] s;
        s = {1'b0, a} + {17'b0, b};
        sat_add48 = s[DIFF_W] ? MAX48 : s[DIFF_W-1:0];
    endfunction

endpackage

// ----- sv/rda_if.sv -----
// Channel interfaces of the replica diffusion accumulator: item input,
// result output and register write.
// Depends on rda_pkg.
interface rda_in_if;
    logic                       valid;
    logic                       ready;
    logic [rda_pkg::MODE_W-1:0] mode;
    logic [rda_pkg::IDX_W-1:0]  replica;
    logic [rda_pkg::IDX_W-1:0]  position;
    logic [rda_pkg::IDX_W-1:0]  read_from;
    logic [rda_pkg::IDX_W-1:0]  read_to;

    modport source (output valid, mode, replica, position, read_from, read_to,
                    input ready);
    modport sink   (input valid, mode, replica, position, read_from, read_to,
                    output ready);
endinterface

interface rda_out_if;
    logic                        valid;
    logic                        ready;
    logic [rda_pkg::DIFF_W-1:0]  diffusion_value;
    logic [rda_pkg::SINCE_W-1:0] elapsed_steps;
    logic [rda_pkg::DIFF_W-1:0]  elapsed_sum;

    modport source (output valid, diffusion_value, elapsed_steps, elapsed_sum,
                    input ready);
    modport sink   (input valid, diffusion_value, elapsed_steps, elapsed_sum,
                    output ready);
endinterface

interface rda_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rda_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- sv/replica_diffusion_accumulator.sv -----
// Replica diffusion accumulator top level: since-visit and diffusion
// matrices in two synchronous memories, row sweep pipeline, step counters.
// Depends on rda_pkg and the interfaces in rda_if.sv.
//
//  channel | dir | word
//  i_in    | in  | mode, replica, position, read_from, read_to
//  o_out   | out | diffusion_value, elapsed_steps, elapsed_sum
//  i_cfg   | in  | active_replicas (data), always ready
//
// A record word sweeps every column of one since-visit row and one diffusion
// row through a three-stage read/modify/write pipeline on the two memory
// ports. A read steps through S_RD_ADDR and S_RD_DATA to S_OUT; a clear, an
// unused code or an out-of-range record goes straight to S_OUT. One word is
// worked at a time. Reset is synchronous; row valid flops make both matrices
// read as zero at once, so there is no clearing pass. A stalled o_out holds
// the result; the next word is still taken and waits for the output register.
module replica_diffusion_accumulator #(
    parameter int NUM_REPLICAS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rda_in_if.sink    i_in,
    rda_out_if.source o_out,
    rda_cfg_if.sink   i_cfg
);
    import rda_pkg::*;

    localparam int CW    = $clog2(NUM_REPLICAS);
    localparam int NW    = $clog2(NUM_REPLICAS + 1);
    localparam int AW    = $clog2(NUM_REPLICAS * NUM_REPLICAS);
    localparam int CELLS = NUM_REPLICAS * NUM_REPLICAS;

    // Matrices
    logic [SINCE_W-1:0] r_sv_mem [CELLS];
    logic [DIFF_W-1:0]  r_ds_mem [CELLS];
    logic [SINCE_W-1:0] r_sv_q;
    logic [DIFF_W-1:0]  r_ds_q;

    // Control
    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_cfg;
    logic [SINCE_W-1:0]    r_step;
    logic [DIFF_W-1:0]     r_sum;
    logic                  r_sum_pend;
    logic [NUM_REPLICAS-1:0] r_sv_rowv;
    logic [NUM_REPLICAS-1:0] r_ds_rowv;
    logic                  r_issue;
    logic                  r_p1_vld;
    logic                  r_p2_vld;
    logic                  r_out_valid;

    // Payload
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      r_p1_col;
    logic [CW-1:0]      r_p2_col;
    logic [CW-1:0]      r_rep;
    logic [CW-1:0]      r_pos;
    logic [CW-1:0]      r_rd_row;
    logic [CW-1:0]      r_rd_col;
    logic               r_rd_ok;
    logic               r_sv_v;
    logic               r_ds_v;
    logic               r_p2_in;
    logic [SINCE_W-1:0] r_p2_sv;
    logic [DIFF_W-1:0]  r_p2_ds;
    logic [DIFF_W-1:0]  r_val;
    logic [DIFF_W-1:0]  r_out_diff;
    logic [SINCE_W-1:0] r_out_steps;
    logic [DIFF_W-1:0]  r_out_sum;

    logic [NW-1:0]      w_n;
    logic               w_in_ready;
    logic               w_fire;
    logic               w_rec_ok;
    logic               w_rd_ok;
    logic               w_step_open;
    logic               w_sweep_done;
    logic               w_load;
    logic [AW-1:0]      w_sv_raddr;
    logic [AW-1:0]      w_ds_raddr;
    logic [AW-1:0]      w_sv_waddr;
    logic [AW-1:0]      w_ds_waddr;
    logic               w_p1_in;
    logic [SINCE_W-1:0] w_sv_old;
    logic [SINCE_W-1:0] w_sv_new;
    logic [DIFF_W-1:0]  w_ds_new;

    // Active count, clamped to 1..NUM_REPLICAS
    always_comb begin
        if (r_cfg == '0) begin
            w_n = NW'(1);
        end else if (32'(r_cfg) > 32'(NUM_REPLICAS)) begin
            w_n = NW'(NUM_REPLICAS);
        end else begin
            w_n = NW'(r_cfg);
        end
    end

    // Handshake and range checks
    assign w_in_ready   = (r_state == S_IDLE);
    assign w_fire       = i_in.valid && w_in_ready;
    assign w_rec_ok     = (32'(i_in.replica) < 32'(w_n)) && (32'(i_in.position) < 32'(w_n));
    assign w_rd_ok      = (32'(i_in.read_from) < 32'(w_n)) && (32'(i_in.read_to) < 32'(w_n));
    assign w_step_open  = w_fire && (i_in.mode == MODE_RECORD) && w_rec_ok
                          && (i_in.replica == '0);
    assign w_sweep_done = !r_issue && !r_p1_vld && !r_p2_vld;
    assign w_load       = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    case (i_in.mode)
                        MODE_RECORD: n_state = w_rec_ok ? S_SWEEP : S_OUT;
                        MODE_READ:   n_state = S_RD_ADDR;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_SWEEP:   if (w_sweep_done) n_state = S_OUT;
            S_RD_ADDR: n_state = S_RD_DATA;
            S_RD_DATA: n_state = S_OUT;
            S_OUT:     if (w_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory addresses, sweep stage-2 and stage-3 arithmetic
    always_comb begin
        w_sv_raddr = AW'(r_rep) * AW'(NUM_REPLICAS) + AW'(r_col);
        if (r_state == S_RD_ADDR) begin
            w_ds_raddr = AW'(r_rd_row) * AW'(NUM_REPLICAS) + AW'(r_rd_col);
        end else begin
            w_ds_raddr = AW'(r_pos) * AW'(NUM_REPLICAS) + AW'(r_col);
        end
        w_sv_waddr = AW'(r_rep) * AW'(NUM_REPLICAS) + AW'(r_p1_col);
        w_ds_waddr = AW'(r_pos) * AW'(NUM_REPLICAS) + AW'(r_p2_col);

        // columns past the active count are written back unchanged
        w_p1_in  = NW'(r_p1_col) < w_n;
        w_sv_old = r_sv_v ? r_sv_q : '0;
        if (!w_p1_in) begin
            w_sv_new = w_sv_old;
        end else if (r_p1_col == r_pos) begin
            w_sv_new = '0;
        end else begin
            w_sv_new = sat_inc32(w_sv_old);
        end
        w_ds_new = r_p2_in ? sat_add48(r_p2_ds, r_p2_sv) : r_p2_ds;
    end

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_sv_mem[w_sv_waddr] <= w_sv_new;
        end
        if (r_p2_vld) begin
            r_ds_mem[w_ds_waddr] <= w_ds_new;
        end
        r_sv_q <= r_sv_mem[w_sv_raddr];
        r_ds_q <= r_ds_mem[w_ds_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_step      <= '0;
            r_sum       <= '0;
            r_sum_pend  <= 1'b0;
            r_sv_rowv   <= '0;
            r_ds_rowv   <= '0;
            r_issue     <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cfg <= i_cfg.data;
            end

            // record opening a step bumps the count, sum follows in the cycle after
            r_sum_pend <= w_step_open;
            if (r_sum_pend) begin
                r_sum <= sat_add48(r_sum, r_step);
            end
            if (w_step_open) begin
                r_step <= sat_inc32(r_step);
            end

            // row sweep issue and pipeline valids
            r_p1_vld <= r_issue;
            r_p2_vld <= r_p1_vld;
            if (w_fire && i_in.mode == MODE_RECORD && w_rec_ok) begin
                r_issue <= 1'b1;
            end else if (r_issue && 32'(r_col) == 32'(NUM_REPLICAS - 1)) begin
                r_issue <= 1'b0;
            end

            // row valid flops
            if (w_fire && i_in.mode == MODE_CLEAR) begin
                r_sv_rowv <= '0;
                r_ds_rowv <= '0;
            end else if (r_state == S_SWEEP && w_sweep_done) begin
                r_sv_rowv[r_rep] <= 1'b1;
                r_ds_rowv[r_pos] <= 1'b1;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_col    <= '0;
            r_rep    <= CW'(i_in.replica);
            r_pos    <= CW'(i_in.position);
            r_rd_row <= CW'(i_in.read_from);
            r_rd_col <= CW'(i_in.read_to);
            r_rd_ok  <= w_rd_ok;
            r_sv_v   <= r_sv_rowv[CW'(i_in.replica)];
            r_ds_v   <= (i_in.mode == MODE_READ) ? r_ds_rowv[CW'(i_in.read_from)]
                                                 : r_ds_rowv[CW'(i_in.position)];
            r_val    <= '0;
        end else if (r_issue) begin
            r_col <= r_col + CW'(1);
        end
        r_p1_col <= r_col;
        r_p2_col <= r_p1_col;
        r_p2_in  <= w_p1_in;
        r_p2_sv  <= w_sv_new;
        r_p2_ds  <= r_ds_v ? r_ds_q : '0;
        if (r_state == S_RD_DATA) begin
            r_val <= (r_rd_ok && r_ds_v) ? r_ds_q : '0;
        end
        if (w_load) begin
            r_out_diff  <= r_val;
            r_out_steps <= r_step;
            r_out_sum   <= r_sum;
        end
    end

    // Ports
    assign i_in.ready            = w_in_ready;
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.diffusion_value = r_out_diff;
    assign o_out.elapsed_steps   = r_out_steps;
    assign o_out.elapsed_sum     = r_out_sum;

    // Checks
    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> (!r_issue && !r_p1_vld && !r_p2_vld && !r_sum_pend))
        else $error("word accepted while sweep still busy");

    a_step_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_step >= $past(r_step))
        else $error("step count went down");

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_sum >= $past(r_sum))
        else $error("step sum went down");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("loaded result not presented");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for replica_diffusion_accumulator: directed and random words.
// A word-level predictor of both matrices and the step counters checks every result.
// Depends on rda_pkg, rda_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import rda_pkg::*;

    localparam int NUM_REP = 16;
    localparam int CELLS = NUM_REP * NUM_REP;
    // settle time after the last result before a register write or the end
    localparam int SETTLE_CYCLES = NUM_REP + 10;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [DIFF_W-1:0]  value;
        logic [SINCE_W-1:0] steps;
        logic [DIFF_W-1:0]  sum;
    } t_acc_result;

    logic i_clk;
    logic i_rst_n;

    rda_in_if  in_if ();
    rda_out_if out_if ();
    rda_cfg_if cfg_if ();

    replica_diffusion_accumulator #(
        .NUM_REPLICAS(NUM_REP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // predicted block state
    logic [SINCE_W-1:0] since_mem [CELLS];
    logic [DIFF_W-1:0]  diff_mem  [CELLS];
    logic [SINCE_W-1:0] step_cnt;
    logic [DIFF_W-1:0]  step_sum;
    logic [CFG_W-1:0]   active_reg;

    t_acc_result expected_results [$];
    int unsigned words_sent;
    int unsigned errors;
    int unsigned stall_left;
    bit          idling_on;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic logic [DIFF_W-1:0] add_clip48(input logic [DIFF_W-1:0] a,
                                                     input logic [SINCE_W-1:0] b);
        logic [DIFF_W:0] s;
        s = {1'b0, a} + {{(DIFF_W-SINCE_W+1){1'b0}}, b};
        return s[DIFF_W] ? MAX48 : s[DIFF_W-1:0];
    endfunction

    // register value clamped to 1..NUM_REP
    function automatic int unsigned live_count();
        if (active_reg == 0) return 1;
        if (active_reg > NUM_REP) return NUM_REP;
        return 32'(active_reg);
    endfunction

    function automatic void clear_matrices();
        for (int c = 0; c < CELLS; c++) begin
            since_mem[c] = '0;
            diff_mem[c]  = '0;
        end
    endfunction

    function automatic t_acc_result accumulate_word(input logic [MODE_W-1:0] mode,
                                                    input logic [IDX_W-1:0] rep,
                                                    input logic [IDX_W-1:0] pos,
                                                    input logic [IDX_W-1:0] rf,
                                                    input logic [IDX_W-1:0] rt);
        t_acc_result res;
        int unsigned n;
        int unsigned row;
        int unsigned drow;
        n = live_count();
        res.value = '0;
        if (mode == MODE_RECORD) begin
            // out-of-range record leaves everything alone
            if (rep < n && pos < n) begin
                row  = rep * NUM_REP;
                drow = pos * NUM_REP;
                if (rep == 0) begin
                    if (step_cnt != MAX32) step_cnt = step_cnt + 1;
                    step_sum = add_clip48(step_sum, step_cnt);
                end
                for (int c = 0; c < n; c++) begin
                    if (since_mem[row + c] != MAX32) since_mem[row + c] = since_mem[row + c] + 1;
                end
                since_mem[row + pos] = '0;
                for (int c = 0; c < n; c++) begin
                    diff_mem[drow + c] = add_clip48(diff_mem[drow + c], since_mem[row + c]);
                end
            end
        end else if (mode == MODE_READ) begin
            if (rf < n && rt < n) res.value = diff_mem[rf * NUM_REP + rt];
        end else if (mode == MODE_CLEAR) begin
            clear_matrices();
        end
        res.steps = step_cnt;
        res.sum   = step_sum;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // result checker and output stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_acc_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word: value %0d steps %0d sum %0d",
                         $time, out_if.diffusion_value, out_if.elapsed_steps,
                         out_if.elapsed_sum);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_if.diffusion_value !== want.value) begin
                    $display("%0t: diffusion_value expected %0d, actual %0d",
                             $time, want.value, out_if.diffusion_value);
                    errors++;
                end
                if (out_if.elapsed_steps !== want.steps) begin
                    $display("%0t: elapsed_steps expected %0d, actual %0d",
                             $time, want.steps, out_if.elapsed_steps);
                    errors++;
                end
                if (out_if.elapsed_sum !== want.sum) begin
                    $display("%0t: elapsed_sum expected %0d, actual %0d",
                             $time, want.sum, out_if.elapsed_sum);
                    errors++;
                end
            end
        end
        // ready for the next cycle; while idling is on, stalls come in bursts
        if (stall_left != 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] rep,
                             input logic [IDX_W-1:0] pos, input logic [IDX_W-1:0] rf,
                             input logic [IDX_W-1:0] rt);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= mode;
        in_if.replica   <= rep;
        in_if.position  <= pos;
        in_if.read_from <= rf;
        in_if.read_to   <= rt;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_results.push_back(accumulate_word(mode, rep, pos, rf, rt));
        words_sent++;
    endtask

    task automatic send_record(input int rep, input int pos);
        send_word(MODE_RECORD, IDX_W'(rep), IDX_W'(pos),
                  IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)));
    endtask

    task automatic send_read(input int rf, input int rt);
        send_word(MODE_READ, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                  IDX_W'(rf), IDX_W'(rt));
    endtask

    task automatic send_clear();
        send_word(MODE_CLEAR, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                  IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)));
    endtask

    task automatic send_spare();
        send_word(MODE_SPARE, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                  IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)));
    endtask

    // replicas 0..count-1 in order; positions a shuffle or plain random
    task automatic send_step(input int unsigned n, input int unsigned count);
        int perm [NUM_REP];
        int j;
        int tmp;
        bit shuffled;
        shuffled = ($urandom_range(0, 9) < 6);
        for (int r = 0; r < NUM_REP; r++) perm[r] = r;
        for (int r = n - 1; r > 0; r--) begin
            j = $urandom_range(0, r);
            tmp = perm[r];
            perm[r] = perm[j];
            perm[j] = tmp;
        end
        for (int r = 0; r < count; r++) begin
            send_record(r, shuffled ? perm[r] : $urandom_range(0, n - 1));
        end
    endtask

    // hold off the sender until every result is back
    task automatic pause_for_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic settle_block();
        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_active(input logic [CFG_W-1:0] v);
        settle_block();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        active_reg = v;
    endtask

    // mixed traffic: mostly whole steps, some reads, noise and broken steps
    task automatic run_traffic(input int unsigned budget);
        int unsigned n;
        int unsigned stop_at;
        int unsigned pause_at;
        int unsigned pick;
        bit paused;
        n = live_count();
        stop_at  = words_sent + budget;
        pause_at = words_sent + $urandom_range(0, budget);
        paused   = 1'b0;
        while (words_sent < stop_at) begin
            if (!paused && words_sent >= pause_at) begin
                pause_for_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                send_step(n, n);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 4) == 0)
                        send_read($urandom_range(0, 15), $urandom_range(0, 15));
                    else
                        send_read($urandom_range(0, n - 1), $urandom_range(0, n - 1));
                end
            end else if (pick < 88) begin
                send_clear();
            end else if (pick < 91) begin
                send_spare();
            end else if (pick < 95) begin
                send_step(n, $urandom_range(1, n));
            end else begin
                send_record($urandom_range(0, 15), $urandom_range(0, 15));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_reset_values();
        send_read(0, 0);
        send_read(15, 15);
        send_spare();
        send_clear();
    endtask

    task automatic test_register_extremes();
        // zero is used as one replica
        set_active(5'd0);
        send_record(0, 0);
        send_record(1, 0);
        send_record(0, 1);
        send_read(0, 0);
        send_read(0, 1);
        // above the built size is used as the built size
        set_active(5'd31);
        send_record(15, 15);
        send_record(0, 15);
        send_read(15, 15);
        send_read(15, 0);
        // two replicas trading places, then a clear
        set_active(5'd2);
        send_record(0, 1);
        send_record(1, 0);
        send_record(0, 0);
        send_record(1, 1);
        send_read(1, 0);
        send_read(0, 1);
        send_clear();
        send_read(0, 1);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] settings [9];
        settings = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd9, 5'd0, 5'd16, 5'd2,
                     5'($urandom_range(1, 16))};
        foreach (settings[k]) begin
            set_active(settings[k]);
            idling_on = ($urandom_range(0, 3) != 0);
            run_traffic(165);
        end
        idling_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        set_active(5'd8);
        send_step(8, 8);
        pause_for_results();
        send_read($urandom_range(0, 7), $urandom_range(0, 7));
        send_step(8, 8);
    endtask

    task automatic test_no_idling();
        set_active(5'd16);
        idling_on = 1'b0;
        run_traffic(110);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        in_if.valid     = 1'b0;
        in_if.mode      = MODE_RECORD;
        in_if.replica   = '0;
        in_if.position  = '0;
        in_if.read_from = '0;
        in_if.read_to   = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        out_if.ready    = 1'b0;
        i_rst_n         = 1'b0;
        stall_left      = 0;
        idling_on       = 1'b1;
        words_sent      = 0;
        errors          = 0;
        clear_matrices();
        step_cnt   = '0;
        step_sum   = '0;
        active_reg = CFG_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_extremes();
        test_random_traffic();
        test_sender_pause();
        test_no_idling();

        settle_block();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rda_pkg.sv
sv/rda_if.sv
sv/replica_diffusion_accumulator.sv
verif/tb_top.sv
